// ----- design/lbsu_pkg.sv -----
// Package for the linearized bicycle state update block.
// Holds the shared types, the fixed-point constants, the arctangent table and a saturation function.
// It depends on nothing else.
`default_nettype none
package lbsu_pkg;

	// Number of CORDIC micro-rotations and the working width of the CORDIC datapath.
	localparam int CORDIC_STEPS = 24;
	localparam int CW           = 34;

	// CORDIC start value (inverse gain) and the angle scaling factors.
	localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam logic signed [30:0]   INV_TWO_PI_Q32  = 31'sd683565276;
	localparam logic signed [32:0]   TWO_PI_Q29      = 33'sd3373259426;

	// Quadrant of the reduced angle.
	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// Per-item data that travels beside the CORDIC.
	typedef struct packed {
		logic signed [31:0]   px;
		logic signed [31:0]   py;
		logic signed [31:0]   v;
		logic signed [31:0]   th;
		logic signed [31:0]   a;
		logic signed [CW-1:0] e;
		logic signed [31:0]   nv;
		logic signed [31:0]   nt;
		quad_t                q;
	} side_t;

	// Rounded Q4.30 arctangent of 2^-idx.
	function automatic logic signed [CW-1:0] atan_q30(input int unsigned idx);
		case (idx)
			0:       atan_q30 = 34'sd843314857;
			1:       atan_q30 = 34'sd497837829;
			2:       atan_q30 = 34'sd263043837;
			3:       atan_q30 = 34'sd133525159;
			4:       atan_q30 = 34'sd67021687;
			5:       atan_q30 = 34'sd33543516;
			6:       atan_q30 = 34'sd16775851;
			7:       atan_q30 = 34'sd8388437;
			8:       atan_q30 = 34'sd4194283;
			9:       atan_q30 = 34'sd2097149;
			10:      atan_q30 = 34'sd1048576;
			11:      atan_q30 = 34'sd524288;
			12:      atan_q30 = 34'sd262144;
			13:      atan_q30 = 34'sd131072;
			14:      atan_q30 = 34'sd65536;
			15:      atan_q30 = 34'sd32768;
			16:      atan_q30 = 34'sd16384;
			17:      atan_q30 = 34'sd8192;
			18:      atan_q30 = 34'sd4096;
			19:      atan_q30 = 34'sd2048;
			20:      atan_q30 = 34'sd1024;
			21:      atan_q30 = 34'sd512;
			22:      atan_q30 = 34'sd256;
			23:      atan_q30 = 34'sd128;
			default: atan_q30 = 34'sd0;
		endcase
	endfunction

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [71:0] val);
		if (val > 72'sd2147483647) begin
			sat32 = 32'sh7fffffff;
		end else if (val < -72'sd2147483648) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = val[31:0];
		end
	endfunction

endpackage
`default_nettype wire

// ----- design/lbsu_front.sv -----
// Front end of the state update: angle reduction, speed and heading updates.
// Three pipeline stages; uses lbsu_pkg for the constants and the side record.
`default_nettype none
module lbsu_front #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic signed [31:0]  pos_x,
	input  wire logic signed [31:0]  pos_y,
	input  wire logic signed [31:0]  speed,
	input  wire logic signed [31:0]  heading,
	input  wire logic signed [31:0]  accel,
	input  wire logic signed [31:0]  heading_rate,
	input  wire logic        [15:0]  t,
	output logic                     out_valid,
	output logic signed [33:0]       z,
	output lbsu_pkg::side_t          side
);
	import lbsu_pkg::*;

	logic signed [16:0] t17;
	assign t17 = $signed({1'b0, t});

	// Stage 1 registers.
	logic               v_s1;
	logic signed [31:0] px_s1, py_s1, v_in_s1, th_s1, a_s1;
	logic signed [62:0] prod_s1;
	logic signed [48:0] at_s1, vt_s1, wt_s1;

	// Stage 2 registers.
	logic               v_s2;
	logic signed [31:0] px_s2, py_s2, v_in_s2, th_s2, a_s2;
	logic signed [64:0] rmul_s2;
	logic signed [65:0] att_s2;
	logic signed [32:0] vtr_s2;
	logic signed [31:0] nv_s2, nt_s2;
	quad_t              q_s2;

	// Stage 3 registers.
	logic               v_s3;
	logic signed [33:0] z_s3;
	side_t              side_s3;

	// Stage 2 combinational terms.
	logic        [31:0] phase;
	logic        [31:0] qsum;
	logic signed [31:0] r;
	logic signed [48:0] atr_w, wtr_w, vtr_w;
	logic signed [32:0] atr, wtr;

	// Stage 3 combinational terms.
	logic signed [64:0] z_w;
	logic signed [65:0] att_w;
	logic signed [32:0] attr;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: angle to turns and the products with the sample time.
	always_ff @(posedge clk) begin
		px_s1   <= pos_x;
		py_s1   <= pos_y;
		v_in_s1 <= speed;
		th_s1   <= heading;
		a_s1    <= accel;
		prod_s1 <= 63'(heading) * 63'(INV_TWO_PI_Q32);
		at_s1   <= 49'(accel) * 49'(t17);
		vt_s1   <= 49'(speed) * 49'(t17);
		wt_s1   <= 49'(heading_rate) * 49'(t17);
	end

	// Stage 2 logic: quadrant split and rounding of the time products.
	always_comb begin
		phase = prod_s1[FRAC_BITS+31 -: 32];
		qsum  = phase + 32'h2000_0000;
		r     = $signed(phase - {qsum[31:30], 30'b0});
		atr_w = (at_s1 + 49'sd32768) >>> 16;
		wtr_w = (wt_s1 + 49'sd32768) >>> 16;
		vtr_w = (vt_s1 + 49'sd32768) >>> 16;
		atr   = atr_w[32:0];
		wtr   = wtr_w[32:0];
	end

	always_ff @(posedge clk) begin
		px_s2   <= px_s1;
		py_s2   <= py_s1;
		v_in_s2 <= v_in_s1;
		th_s2   <= th_s1;
		a_s2    <= a_s1;
		rmul_s2 <= 65'(r) * 65'(TWO_PI_Q29);
		att_s2  <= 66'(at_s1) * 66'(t17);
		vtr_s2  <= vtr_w[32:0];
		nv_s2   <= sat32(72'(v_in_s1) + 72'(atr));
		nt_s2   <= sat32(72'(th_s1) + 72'(wtr));
		q_s2    <= quad_t'(qsum[31:30]);
	end

	// Stage 3 logic: angle in radians and the distance term.
	always_comb begin
		z_w   = (rmul_s2 + 65'sd1073741824) >>> 31;
		att_w = (att_s2 + 66'sd4294967296) >>> 33;
		attr  = att_w[32:0];
	end

	always_ff @(posedge clk) begin
		z_s3       <= z_w[33:0];
		side_s3.px <= px_s2;
		side_s3.py <= py_s2;
		side_s3.v  <= v_in_s2;
		side_s3.th <= th_s2;
		side_s3.a  <= a_s2;
		side_s3.e  <= 34'(vtr_s2) + 34'(attr);
		side_s3.nv <= nv_s2;
		side_s3.nt <= nt_s2;
		side_s3.q  <= q_s2;
	end

	assign out_valid = v_s3;
	assign z         = z_s3;
	assign side      = side_s3;

endmodule
`default_nettype wire

// ----- design/lbsu_cordic.sv -----
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
// Carries the side record along; uses lbsu_pkg for the table and types.
`default_nettype none
module lbsu_cordic (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic signed [33:0] z_in,
	input  wire lbsu_pkg::side_t   side_in,
	output logic                   out_valid,
	output logic signed [33:0]     x_out,
	output logic signed [33:0]     y_out,
	output lbsu_pkg::side_t        side_out
);
	import lbsu_pkg::*;

	// Stage k holds the vector after k micro-rotations.
	logic               cv_s  [0:CORDIC_STEPS];
	logic signed [CW-1:0] cx_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] cy_s [0:CORDIC_STEPS];
	logic signed [CW-1:0] cz_s [0:CORDIC_STEPS];
	side_t              cd_s  [0:CORDIC_STEPS];

	assign cv_s[0] = in_valid;
	assign cx_s[0] = CORDIC_GAIN_Q30;
	assign cy_s[0] = '0;
	assign cz_s[0] = z_in;
	assign cd_s[0] = side_in;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [CW-1:0] ATAN = atan_q30(i);

		// Valid bit of this stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[i+1] <= 1'b0;
			end else begin
				cv_s[i+1] <= cv_s[i];
			end
		end

		// Rotate toward zero residual angle.
		always_ff @(posedge clk) begin
			if (!cz_s[i][CW-1]) begin
				cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] - ATAN;
			end else begin
				cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] + ATAN;
			end
			cd_s[i+1] <= cd_s[i];
		end
	end

	assign out_valid = cv_s[CORDIC_STEPS];
	assign x_out     = cx_s[CORDIC_STEPS];
	assign y_out     = cy_s[CORDIC_STEPS];
	assign side_out  = cd_s[CORDIC_STEPS];

endmodule
`default_nettype wire

// ----- design/lbsu_back.sv -----
// Back end: quadrant fix-up, matrix entries, products and saturated sums.
// Five pipeline stages; uses lbsu_pkg for the side record and saturation.
`default_nettype none
module lbsu_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic signed [33:0] x_in,
	input  wire logic signed [33:0] y_in,
	input  wire lbsu_pkg::side_t    side_in,
	input  wire logic        [15:0] t,
	input  wire logic        [31:0] h,
	output logic                    out_valid,
	output logic signed [31:0]      next_pos_x,
	output logic signed [31:0]      next_pos_y,
	output logic signed [31:0]      next_speed,
	output logic signed [31:0]      next_heading
);
	import lbsu_pkg::*;

	localparam logic signed [65:0] HALF_F = 66'sd1 <<< (FRAC_BITS - 1);

	logic signed [16:0] t17;
	logic signed [32:0] h33;
	assign t17 = $signed({1'b0, t});
	assign h33 = $signed({1'b0, h});

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t              d_s1, d_s2, d_s3, d_s4;
	logic signed [33:0] c_s1, s_s1;
	logic signed [33:0] a02_s2, a12_s2, b00_s2, b10_s2, a03_s2, a13_s2;
	logic signed [65:0] p1x_s3, p2x_s3, p3x_s3, p1y_s3, p2y_s3, p3y_s3;
	logic signed [35:0] t1x_s4, t1y_s4;
	logic signed [65:0] t2x_s4, t2y_s4;
	logic signed [31:0] nx_s5, ny_s5, nv_s5, nt_s5;

	// Stage 2 combinational terms.
	logic signed [50:0] ct, st;
	logic signed [66:0] ch, sh;
	logic signed [67:0] es, ec;
	logic signed [50:0] ct_r, st_r;
	logic signed [66:0] ch_r, sh_r;
	logic signed [67:0] es_r, ec_r;
	logic signed [33:0] a03_pos;

	// Stage 4 combinational terms.
	logic signed [66:0] sx, sy, sx_r, sy_r;

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: rotate cosine and sine into the right quadrant.
	always_ff @(posedge clk) begin
		unique case (side_in.q)
			QUAD_0: begin
				c_s1 <= x_in;
				s_s1 <= y_in;
			end
			QUAD_1: begin
				c_s1 <= -y_in;
				s_s1 <= x_in;
			end
			QUAD_2: begin
				c_s1 <= -x_in;
				s_s1 <= -y_in;
			end
			QUAD_3: begin
				c_s1 <= y_in;
				s_s1 <= -x_in;
			end
		endcase
		d_s1 <= side_in;
	end

	// Stage 2 logic: linearized matrix entries.
	always_comb begin
		ct      = 51'(c_s1) * 51'(t17);
		st      = 51'(s_s1) * 51'(t17);
		ch      = 67'(c_s1) * 67'(h33);
		sh      = 67'(s_s1) * 67'(h33);
		es      = 68'(d_s1.e) * 68'(s_s1);
		ec      = 68'(d_s1.e) * 68'(c_s1);
		ct_r    = (ct + 51'sd32768) >>> 16;
		st_r    = (st + 51'sd32768) >>> 16;
		ch_r    = (ch + 67'sd4294967296) >>> 33;
		sh_r    = (sh + 67'sd4294967296) >>> 33;
		es_r    = (es + 68'sd536870912) >>> 30;
		ec_r    = (ec + 68'sd536870912) >>> 30;
		a03_pos = es_r[33:0];
	end

	always_ff @(posedge clk) begin
		a02_s2 <= ct_r[33:0];
		a12_s2 <= st_r[33:0];
		b00_s2 <= ch_r[33:0];
		b10_s2 <= sh_r[33:0];
		a03_s2 <= -a03_pos;
		a13_s2 <= ec_r[33:0];
		d_s2   <= d_s1;
	end

	// Stage 3: products of the matrix rows with state and control.
	always_ff @(posedge clk) begin
		p1x_s3 <= 66'(a02_s2) * 66'(d_s2.v);
		p2x_s3 <= 66'(b00_s2) * 66'(d_s2.a);
		p3x_s3 <= 66'(a03_s2) * 66'(d_s2.th);
		p1y_s3 <= 66'(a12_s2) * 66'(d_s2.v);
		p2y_s3 <= 66'(b10_s2) * 66'(d_s2.a);
		p3y_s3 <= 66'(a13_s2) * 66'(d_s2.th);
		d_s3   <= d_s2;
	end

	// Stage 4 logic: round the product sums back to the state format.
	always_comb begin
		sx   = 67'(p1x_s3) + 67'(p2x_s3);
		sy   = 67'(p1y_s3) + 67'(p2y_s3);
		sx_r = (sx + 67'sd536870912) >>> 30;
		sy_r = (sy + 67'sd536870912) >>> 30;
	end

	always_ff @(posedge clk) begin
		t1x_s4 <= sx_r[35:0];
		t1y_s4 <= sy_r[35:0];
		t2x_s4 <= (p3x_s3 + HALF_F) >>> FRAC_BITS;
		t2y_s4 <= (p3y_s3 + HALF_F) >>> FRAC_BITS;
		d_s4   <= d_s3;
	end

	// Stage 5: add the current position and saturate.
	always_ff @(posedge clk) begin
		nx_s5 <= sat32(72'(d_s4.px) + 72'(t1x_s4) + 72'(t2x_s4));
		ny_s5 <= sat32(72'(d_s4.py) + 72'(t1y_s4) + 72'(t2y_s4));
		nv_s5 <= d_s4.nv;
		nt_s5 <= d_s4.nt;
	end

	assign out_valid    = v_s5;
	assign next_pos_x   = nx_s5;
	assign next_pos_y   = ny_s5;
	assign next_speed   = nv_s5;
	assign next_heading = nt_s5;

endmodule
`default_nettype wire

// ----- design/linearized_bicycle_state_update.sv -----
// Linearized bicycle state update: next state = A*x + B*u for one item per cycle.
// The pipeline from start to done has 3 front stages, 24 CORDIC stages and 5 back stages.
// Throughput is one item per cycle, set by the one-rotation-per-stage CORDIC pipeline.
// busy stays low, since the receiver cannot stall and the pipeline never holds an item.
// Reset clears all valid bits and loads the sample time register t_q with 6554.
`default_nettype none
module linearized_bicycle_state_update #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] speed,
	input  wire logic signed [31:0] heading,
	input  wire logic signed [31:0] accel,
	input  wire logic signed [31:0] heading_rate,
	input  wire logic               cfg_we,
	input  wire logic        [15:0] cfg_wdata,
	output logic                    done,
	output logic signed [31:0]      next_pos_x,
	output logic signed [31:0]      next_pos_y,
	output logic signed [31:0]      next_speed,
	output logic signed [31:0]      next_heading
);
	import lbsu_pkg::*;

	logic [15:0] t_q;
	logic [31:0] h_q;

	logic               f_valid, c_valid;
	logic signed [33:0] f_z, c_x, c_y;
	side_t              f_side, c_side;

	assign busy = 1'b0;

	// Sample time register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= 16'd6554;
		end else if (cfg_we) begin
			t_q <= cfg_wdata;
		end
	end

	// Square of the sample time, used by the B matrix entries.
	always_ff @(posedge clk) begin
		h_q <= 32'(t_q) * 32'(t_q);
	end

	lbsu_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (start & ~busy),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.speed        (speed),
		.heading      (heading),
		.accel        (accel),
		.heading_rate (heading_rate),
		.t            (t_q),
		.out_valid    (f_valid),
		.z            (f_z),
		.side         (f_side)
	);

	lbsu_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.z_in      (f_z),
		.side_in   (f_side),
		.out_valid (c_valid),
		.x_out     (c_x),
		.y_out     (c_y),
		.side_out  (c_side)
	);

	lbsu_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (c_valid),
		.x_in         (c_x),
		.y_in         (c_y),
		.side_in      (c_side),
		.t            (t_q),
		.h            (h_q),
		.out_valid    (done),
		.next_pos_x   (next_pos_x),
		.next_pos_y   (next_pos_y),
		.next_speed   (next_speed),
		.next_heading (next_heading)
	);

endmodule
`default_nettype wire
